@@ rtl/core/imucf_pkg.sv @@
// imucf_pkg: shared types and constants for the IMU complementary filter.
// Holds the sequencer state type, fixed arithmetic constants and the arctan table.
// No dependencies.
package imucf_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RMUL,
        S_DINIT,
        S_DIV,
        S_DEND,
        S_C1INIT,
        S_C1,
        S_GAIN,
        S_C2INIT,
        S_C2,
        S_C2END,
        S_B1,
        S_B2,
        S_B3,
        S_FIN
    } state_t;

    localparam int MAX_STEPS = 24;
    localparam logic [18:0] RATE_DEN = 19'd131000;
    localparam logic [18:0] RATE_DEN2 = 19'd262000;
    localparam logic [39:0] RATE_HALF = 40'd65500;
    // floor(2^39 / RATE_DEN); quotient estimate is low by at most two
    localparam logic [23:0] RATE_RECIP = 24'd4196609;
    localparam logic [17:0] INV_GAIN_Q16 = 18'd39797;
    localparam logic [16:0] ALPHA_ONE = 17'h10000;
    localparam logic [15:0] ALPHA_RESET = 16'd62915;

    localparam logic [1:0] REG_OFFSET_X = 2'd0;
    localparam logic [1:0] REG_OFFSET_Y = 2'd1;
    localparam logic [1:0] REG_OFFSET_Z = 2'd2;
    localparam logic [1:0] REG_ALPHA = 2'd3;

    // atan(2^-i) in 2^-16 degree
    function automatic logic [22:0] atan_tab(input logic [4:0] idx);
        logic [22:0] v;
        case (idx)
            5'd0: v = 23'd2949120;
            5'd1: v = 23'd1740967;
            5'd2: v = 23'd919879;
            5'd3: v = 23'd466945;
            5'd4: v = 23'd234379;
            5'd5: v = 23'd117304;
            5'd6: v = 23'd58666;
            5'd7: v = 23'd29335;
            5'd8: v = 23'd14668;
            5'd9: v = 23'd7334;
            5'd10: v = 23'd3667;
            5'd11: v = 23'd1833;
            5'd12: v = 23'd917;
            5'd13: v = 23'd458;
            5'd14: v = 23'd229;
            5'd15: v = 23'd115;
            5'd16: v = 23'd57;
            5'd17: v = 23'd29;
            5'd18: v = 23'd14;
            5'd19: v = 23'd7;
            5'd20: v = 23'd4;
            5'd21: v = 23'd2;
            5'd22: v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/imu_complementary_filter_top.sv @@
// imu_complementary_filter_top: roll/pitch/yaw complementary filter, one word per sample.
// The second CORDIC pass of a tilt is skipped when its vector is zero; the next sample is taken
// in the same cycle that the result is out.
// Built around one shared multiplier (rate scaling by reciprocal, gain, blend) and one shared
// CORDIC datapath; the output register lets the next sample enter while a result waits.
// Reset clears angle state, offsets to 0 and alpha to 0.96. Depends on imucf_pkg.
module imu_complementary_filter_top
    import imucf_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_x,
    input  logic signed [15:0] gyro_y,
    input  logic signed [15:0] gyro_z,
    input  logic        [15:0] elapsed_ms,
    output logic               angle_valid,
    input  logic               angle_stall,
    output logic signed [23:0] roll_angle,
    output logic signed [23:0] pitch_angle,
    output logic signed [31:0] yaw_angle,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [1:0]  cfg_index,
    input  logic        [15:0] cfg_data
);

    localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    localparam logic [4:0] CORD_LAST = 5'(STEPS - 1);

    state_t state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic [4:0] cnt_reg, cnt_next;

    logic signed [15:0] off_x_reg, off_y_reg, off_z_reg;
    logic [15:0] alpha_reg;

    logic signed [15:0] ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic [15:0] ms_reg, ms_next;
    logic signed [16:0] diff_reg [3];
    logic signed [16:0] diff_next [3];
    logic signed [23:0] d_reg [3];
    logic signed [23:0] d_next [3];
    logic signed [45:0] prod_reg, prod_next, sum_reg, sum_next;
    logic [18:0] rem_reg, rem_next;
    logic [22:0] quo_reg, quo_next;
    logic signed [27:0] x_reg, x_next, y_reg, y_next;
    logic signed [24:0] z_reg, z_next;
    logic signed [15:0] tilt_reg [2];
    logic signed [15:0] tilt_next [2];
    logic signed [23:0] roll_reg, roll_next, pitch_reg, pitch_next;
    logic signed [31:0] yaw_reg, yaw_next;
    logic signed [23:0] roll_out_reg, roll_out_next, pitch_out_reg, pitch_out_next;
    logic signed [31:0] yaw_out_reg, yaw_out_next;
    logic out_valid_reg, out_valid_next;

    logic signed [33:0] mul_a;
    logic signed [23:0] mul_b;
    logic signed [57:0] mul_p;

    logic signed [16:0] diff_sel;
    logic [16:0] diff_mag;
    logic signed [23:0] d_sel, old_sel;
    logic signed [24:0] s_sum;
    logic signed [16:0] num_sel, a_sel, b_abs;
    logic [39:0] dvd;
    logic [39:0] rem_full;
    logic [22:0] quo_fix;
    logic signed [27:0] xs, ys;
    logic signed [24:0] at;
    logic signed [45:0] r_full, v_full;
    logic signed [29:0] v_sh;
    logic signed [23:0] v_sat;
    logic signed [32:0] yaw_sum;
    logic signed [31:0] yaw_sat;
    logic out_free;

    assign sample_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign angle_valid = out_valid_reg;
    assign roll_angle = roll_out_reg;
    assign pitch_angle = pitch_out_reg;
    assign yaw_angle = yaw_out_reg;
    assign out_free = !out_valid_reg || !angle_stall;

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        diff_sel = diff_reg[axis_reg];
        diff_mag = diff_sel[16] ? 17'(-diff_sel) : 17'(diff_sel);
        d_sel = d_reg[axis_reg];
        old_sel = axis_reg[0] ? pitch_reg : roll_reg;
        s_sum = 25'(old_sel) + 25'(d_sel);
        num_sel = axis_reg[0] ? -17'(ax_reg) : 17'(ay_reg);
        a_sel = axis_reg[0] ? 17'(ay_reg) : 17'(ax_reg);
        b_abs = az_reg[15] ? -17'(az_reg) : 17'(az_reg);
        dvd = {prod_reg[32:0], 7'b0} + RATE_HALF;
        rem_full = dvd - mul_p[39:0];
        quo_fix = quo_reg + 23'(rem_reg >= RATE_DEN) + 23'(rem_reg >= RATE_DEN2);
        xs = x_reg >>> cnt_reg;
        ys = y_reg >>> cnt_reg;
        at = 25'(atan_tab(cnt_reg));
        r_full = (prod_reg + 46'sd32768) >>> 16;
        v_full = sum_reg + prod_reg + 46'sd32768;
        v_sh = v_full[45:16];
        if (v_sh > 30'sd8388607)
            v_sat = 24'sh7FFFFF;
        else if (v_sh < -30'sd8388608)
            v_sat = -24'sh800000;
        else
            v_sat = v_sh[23:0];
        yaw_sum = 33'(yaw_reg) + 33'(d_reg[2]);
        if (yaw_sum > 33'sh07FFFFFFF)
            yaw_sat = 32'sh7FFFFFFF;
        else if (yaw_sum < -33'sh080000000)
            yaw_sat = -32'sh80000000;
        else
            yaw_sat = yaw_sum[31:0];
    end

    always_comb
    begin
        case (state_reg)
            S_RMUL:
            begin
                mul_a = 34'(diff_mag);
                mul_b = {8'b0, ms_reg};
            end
            S_DINIT:
            begin
                mul_a = {1'b0, prod_reg[32:0]};
                mul_b = RATE_RECIP;
            end
            S_DIV:
            begin
                mul_a = {11'b0, quo_reg};
                mul_b = {5'b0, RATE_DEN};
            end
            S_GAIN:
            begin
                mul_a = 34'(x_reg);
                mul_b = {6'b0, INV_GAIN_Q16};
            end
            S_B1:
            begin
                mul_a = 34'(s_sum);
                mul_b = {8'b0, alpha_reg};
            end
            S_B2:
            begin
                mul_a = 34'(tilt_reg[axis_reg[0]]);
                mul_b = {7'b0, ALPHA_ONE - {1'b0, alpha_reg}};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (sample_valid) state_next = S_RMUL;
            S_RMUL:   state_next = S_DINIT;
            S_DINIT:  state_next = S_DIV;
            S_DIV:    state_next = S_DEND;
            S_DEND:   state_next = (axis_reg == 2'd2) ? S_C1INIT : S_RMUL;
            S_C1INIT: state_next = S_C1;
            S_C1:     if (cnt_reg == CORD_LAST) state_next = S_GAIN;
            S_GAIN:   state_next = S_C2INIT;
            S_C2INIT:
            begin
                if (r_full == 46'sd0 && num_sel == 17'sd0)
                    state_next = S_C2END;
                else
                    state_next = S_C2;
            end
            S_C2:     if (cnt_reg == CORD_LAST) state_next = S_C2END;
            S_C2END:  state_next = axis_reg[0] ? S_B1 : S_C1INIT;
            S_B1:     state_next = S_B2;
            S_B2:     state_next = S_B3;
            S_B3:     state_next = axis_reg[0] ? S_FIN : S_B1;
            S_FIN:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        axis_next = axis_reg;
        cnt_next = cnt_reg;
        ax_next = ax_reg;
        ay_next = ay_reg;
        az_next = az_reg;
        ms_next = ms_reg;
        diff_next = diff_reg;
        d_next = d_reg;
        prod_next = prod_reg;
        sum_next = sum_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        tilt_next = tilt_reg;
        roll_next = roll_reg;
        pitch_next = pitch_reg;
        yaw_next = yaw_reg;
        roll_out_next = roll_out_reg;
        pitch_out_next = pitch_out_reg;
        yaw_out_next = yaw_out_reg;
        out_valid_next = out_valid_reg && angle_stall;
        case (state_reg)
            S_IDLE:
            begin
                ax_next = accel_x;
                ay_next = accel_y;
                az_next = accel_z;
                ms_next = elapsed_ms;
                diff_next[0] = 17'(gyro_x) - 17'(off_x_reg);
                diff_next[1] = 17'(gyro_y) - 17'(off_y_reg);
                diff_next[2] = 17'(gyro_z) - 17'(off_z_reg);
                axis_next = 2'd0;
            end
            S_RMUL:
                prod_next = mul_p[45:0];
            S_DINIT:
                quo_next = mul_p[54:32];
            S_DIV:
                rem_next = rem_full[18:0];
            S_DEND:
            begin
                d_next[axis_reg] = diff_sel[16] ? -24'({1'b0, quo_fix})
                                                : 24'({1'b0, quo_fix});
                axis_next = (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
            end
            S_C1INIT:
            begin
                x_next = 28'({b_abs, 8'b0});
                y_next = 28'(a_sel) <<< 8;
                z_next = '0;
                cnt_next = 5'd0;
            end
            S_C1, S_C2:
            begin
                if (!y_reg[27])
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + at;
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - at;
                end
                cnt_next = cnt_reg + 5'd1;
            end
            S_GAIN:
                prod_next = mul_p[45:0];
            S_C2INIT:
            begin
                x_next = r_full[27:0];
                y_next = 28'(num_sel) <<< 8;
                z_next = '0;
                cnt_next = 5'd0;
            end
            S_C2END:
            begin
                tilt_next[axis_reg[0]] = 16'((z_reg + 25'sd256) >>> 9);
                axis_next = axis_reg[0] ? 2'd0 : 2'd1;
            end
            S_B1:
                prod_next = mul_p[45:0];
            S_B2:
            begin
                sum_next = prod_reg;
                prod_next = mul_p[45:0];
            end
            S_B3:
            begin
                if (axis_reg[0])
                    pitch_next = v_sat;
                else
                    roll_next = v_sat;
                axis_next = 2'd1;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    yaw_next = yaw_sat;
                    roll_out_next = roll_reg;
                    pitch_out_next = pitch_reg;
                    yaw_out_next = yaw_sat;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg <= '0;
            cnt_reg <= '0;
            roll_reg <= '0;
            pitch_reg <= '0;
            yaw_reg <= '0;
            out_valid_reg <= 1'b0;
            off_x_reg <= '0;
            off_y_reg <= '0;
            off_z_reg <= '0;
            alpha_reg <= ALPHA_RESET;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg <= axis_next;
            cnt_reg <= cnt_next;
            roll_reg <= roll_next;
            pitch_reg <= pitch_next;
            yaw_reg <= yaw_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_OFFSET_X: off_x_reg <= cfg_data;
                    REG_OFFSET_Y: off_y_reg <= cfg_data;
                    REG_OFFSET_Z: off_z_reg <= cfg_data;
                    REG_ALPHA:    alpha_reg <= cfg_data;
                    default:      alpha_reg <= alpha_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg <= ax_next;
        ay_reg <= ay_next;
        az_reg <= az_next;
        ms_reg <= ms_next;
        diff_reg <= diff_next;
        d_reg <= d_next;
        prod_reg <= prod_next;
        sum_reg <= sum_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        tilt_reg <= tilt_next;
        roll_out_reg <= roll_out_next;
        pitch_out_reg <= pitch_out_next;
        yaw_out_reg <= yaw_out_next;
    end

endmodule
